[rtl/sepo_pkg.sv]
// Package: shared constants, codes, divider request/response types and sine table functions for the oscillator.
package sepo_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int POS_FRAC_BITS    = 14;
  localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);
  localparam int POS_W            = 32;
  localparam int DIV_NUM_W        = (POS_W + IDX_W > 26 + POS_FRAC_BITS) ?
                                    (POS_W + IDX_W) : (26 + POS_FRAC_BITS);
  localparam int DIV_DEN_W        = 33;
  localparam int DIV_Q_W          = DIV_NUM_W;

  localparam logic [IDX_W-1:0] OFS_POS = IDX_W'((3 * SINE_TABLE_DEPTH) / 4);
  localparam logic [IDX_W-1:0] OFS_NEG = IDX_W'(SINE_TABLE_DEPTH / 4);

  localparam logic [1:0] SEG_HUMP_P = 2'd0;
  localparam logic [1:0] SEG_GAP_1  = 2'd1;
  localparam logic [1:0] SEG_HUMP_N = 2'd2;
  localparam logic [1:0] SEG_GAP_2  = 2'd3;

  localparam logic CFG_SAMPLE_RATE = 1'b0;
  localparam logic CFG_AMPLITUDE   = 1'b1;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quo;
  } div_rsp_t;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  function automatic logic [63:0] quarter_sine(input logic [63:0] u);
    logic [63:0] x, x2, term;
    logic signed [63:0] sum;
    x    = (u * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    return sum;
  endfunction

  // Q15 magnitude of quarter-wave point j, where j = DEPTH/4 is the crest; elaboration only
  function automatic logic [15:0] quarter_entry(input int j);
    logic [63:0] v;
    v = (quarter_sine(64'(j) << (32 - IDX_W)) + 64'd16384) >> 15;
    return v[15:0];
  endfunction

endpackage

[rtl/sepo_div.sv]
// Restoring divider, one quotient bit per cycle while busy, full-width quotient.
module sepo_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sepo_pkg::div_req_t req,
  output sepo_pkg::div_rsp_t rsp
);
  localparam int CW = $clog2(sepo_pkg::DIV_NUM_W + 1);

  logic                           busy_r, busy_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic [sepo_pkg::DIV_NUM_W-1:0] num_r, num_nxt;
  logic [sepo_pkg::DIV_DEN_W:0]   rem_r, rem_nxt;
  logic [sepo_pkg::DIV_DEN_W-1:0] den_r, den_nxt;
  logic [sepo_pkg::DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic                           done_r, done_nxt;
  logic [sepo_pkg::DIV_DEN_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    done_nxt = 1'b0;
    trial    = {rem_r[sepo_pkg::DIV_DEN_W-1:0], num_r[sepo_pkg::DIV_NUM_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(sepo_pkg::DIV_NUM_W);
      num_nxt  = req.num;
      den_nxt  = req.den;
      rem_nxt  = '0;
      quo_nxt  = '0;
    end else if (busy_r) begin
      num_nxt = num_r << 1;
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[sepo_pkg::DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[sepo_pkg::DIV_NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  // callers saturate or take the low bits as they need
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
endmodule

[rtl/sine_edged_pulse_oscillator_core.sv]
// Top level: sequencer, shared divider and segment state of the sine-edged pulse oscillator.
// Sequence: a divider pass each for period and sine length, then on a hump with a nonzero
//   half length a third pass for the hump table index; a gap or zero half length skips it.
// Throughput: one item at a time; the next input beat is taken only after out_ready has
//   accepted the result.
// Reset: synchronous active-low rst_n clears segment, position, sequencer and output
//   valid, and loads sample_rate 48000 and amplitude 32767.
module sine_edged_pulse_oscillator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [17:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [23:0]        in_pitch,
  input  logic [23:0]        in_band_freq,
  input  logic [16:0]        in_pulse_width,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample
);
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DPER  = 4'd1;
  localparam logic [3:0] ST_WPER  = 4'd2;
  localparam logic [3:0] ST_WSIN  = 4'd3;
  localparam logic [3:0] ST_GAP   = 4'd4;
  localparam logic [3:0] ST_MUL   = 4'd5;
  localparam logic [3:0] ST_WIDX  = 4'd6;
  localparam logic [3:0] ST_LOOK  = 4'd7;
  localparam logic [3:0] ST_AMP   = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  localparam int F = sepo_pkg::POS_FRAC_BITS;
  localparam int W = sepo_pkg::POS_W;
  localparam int IW = sepo_pkg::IDX_W;
  localparam int QN = sepo_pkg::SINE_TABLE_DEPTH / 4;
  localparam logic [W-1:0] MAX = {W{1'b1}};
  localparam logic [W:0] INC = (W+1)'(1) << F;
  // crest of the quarter wave, the one point past the stored table
  localparam logic [15:0] QTOP = sepo_pkg::quarter_entry(QN);

  logic [3:0]  st_r, st_nxt;
  logic [17:0] rate_r;
  logic [14:0] amp_r;
  logic [23:0] pitch_r, band_r;
  logic [16:0] pw_r;
  logic [W-1:0] per_r, sin_r, gap_r, gsel_r, pos_r;
  logic [1:0]  seg_r;
  logic [IW-1:0] idx_r;
  logic [16:0] su_r;
  logic signed [15:0] res_r;
  logic        ov_r;

  sepo_pkg::div_req_t dreq;
  sepo_pkg::div_rsp_t drsp;
  sepo_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic [W-1:0] dq32;
  logic [W-1:0] half;
  logic [16:0]  pwc;
  logic [48:0]  gprod;
  logic [W:0]   pinc;
  logic [W-1:0] pinc_s;
  logic [W:0]   pgap;
  logic [31:0]  aprod;
  logic hump;
  logic [W+IW-1:0] pscaled;
  logic [15:0]  qtab [QN];
  logic [1:0]   quad;
  logic [IW-2:0] jq;
  logic [15:0]  mag;

  // quarter-wave table, fixed at elaboration; the other quadrants mirror it
  for (genvar j = 0; j < QN; j++) begin : g_qtab
    localparam logic [15:0] QV = sepo_pkg::quarter_entry(j);
    assign qtab[j] = QV;
  end

  assign dq32   = (|drsp.quo[sepo_pkg::DIV_Q_W-1:W]) ? MAX : drsp.quo[W-1:0];
  assign half   = sin_r >> 1;
  assign pwc    = (pw_r > 17'd65536) ? 17'd65536 : pw_r;
  assign hump   = !seg_r[0];
  assign pinc   = {1'b0, pos_r} + INC;
  assign pinc_s = pinc[W] ? MAX : pinc[W-1:0];
  // leaving a gap: position is known to exceed the gap length, so only the top can overflow
  assign pgap   = pinc - {1'b0, gsel_r};
  assign gprod  = 49'(gap_r) * 49'(seg_r[1] ? (17'd65536 - pwc) : pwc);
  assign aprod  = 32'(amp_r) * 32'(su_r);
  assign in_ready = (st_r == ST_IDLE);
  // pos*DEPTH in full; only the quotient modulo DEPTH is kept afterwards
  assign pscaled = {pos_r, IW'(0)};

  // fold the table index onto the quarter wave: odd quadrants run backwards
  assign quad = idx_r[IW-1:IW-2];
  assign jq   = quad[0] ? ((IW-1)'(QN) - {1'b0, idx_r[IW-3:0]}) : {1'b0, idx_r[IW-3:0]};
  assign mag  = jq[IW-2] ? QTOP : qtab[jq[IW-3:0]];

  always_comb begin
    dreq = '0;
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_valid) st_nxt = ST_DPER;
      ST_DPER: begin
        dreq.start = 1'b1;
        dreq.num = sepo_pkg::DIV_NUM_W'({rate_r, (8 + F)'(0)});
        dreq.den = sepo_pkg::DIV_DEN_W'(pitch_r);
        st_nxt = ST_WPER;
      end
      ST_WPER: if (drsp.done) begin
        dreq.start = 1'b1;
        dreq.num = sepo_pkg::DIV_NUM_W'({rate_r, (8 + F)'(0)});
        dreq.den = sepo_pkg::DIV_DEN_W'(band_r);
        st_nxt = ST_WSIN;
      end
      ST_WSIN: if (drsp.done) st_nxt = ST_GAP;
      ST_GAP:  st_nxt = ST_MUL;
      ST_MUL: begin
        if (hump && half != '0) begin
          // index = pos * DEPTH / half
          dreq.start = 1'b1;
          dreq.num = sepo_pkg::DIV_NUM_W'(pscaled);
          dreq.den = sepo_pkg::DIV_DEN_W'(half);
          st_nxt = ST_WIDX;
        end else st_nxt = ST_LOOK;
      end
      ST_WIDX: if (drsp.done) st_nxt = ST_LOOK;
      ST_LOOK: st_nxt = ST_AMP;
      ST_AMP:  st_nxt = ST_OUT;
      ST_OUT:  if (out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      rate_r <= 18'd48000;
      amp_r  <= 15'd32767;
      pos_r  <= '0;
      seg_r  <= sepo_pkg::SEG_HUMP_P;
      ov_r   <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        if (cfg_index == sepo_pkg::CFG_SAMPLE_RATE) rate_r <= cfg_wdata;
        else amp_r <= cfg_wdata[14:0];
      end
      ov_r <= (st_r == ST_AMP) || (ov_r && !out_ready);
      if (st_r == ST_AMP) begin
        if (hump) begin
          pos_r <= (pinc_s >= half) ? pinc_s - half : pinc_s;
          if (pinc_s >= half) seg_r <= seg_r + 2'd1;
        end else if (pos_r > gsel_r) begin
          pos_r <= pgap[W] ? MAX : pgap[W-1:0];
          seg_r <= seg_r + 2'd1;
        end else pos_r <= pinc_s;
      end
    end
    if (st_r == ST_IDLE) begin
      pitch_r <= in_pitch;
      band_r  <= in_band_freq;
      pw_r    <= in_pulse_width;
    end
    if (st_r == ST_WPER && drsp.done) per_r <= (pitch_r == '0) ? MAX : dq32;
    if (st_r == ST_WSIN && drsp.done)
      sin_r <= ((band_r == '0 ? MAX : dq32) > per_r) ? per_r : (band_r == '0 ? MAX : dq32);
    if (st_r == ST_GAP) gap_r <= per_r - sin_r;
    if (st_r == ST_MUL) gsel_r <= gprod[W+15:16];
    if (st_r == ST_MUL) idx_r <= seg_r[1] ? sepo_pkg::OFS_NEG : sepo_pkg::OFS_POS;
    if (st_r == ST_WIDX && drsp.done) idx_r <= idx_r + drsp.quo[IW-1:0];
    // offset sample for the amplitude multiply: a negative entry or the negative hump
    // subtracts from mid-scale; both together add
    if (st_r == ST_LOOK)
      su_r <= (quad[1] ^ seg_r[1]) ? 17'd32768 - {1'b0, mag} : 17'd32768 + {1'b0, mag};
    if (st_r == ST_AMP) res_r <= '0;
    if (st_r == ST_AMP && hump)
      res_r <= seg_r[1] ? -$signed({1'b0, aprod[30:16]}) : $signed({1'b0, aprod[30:16]});
  end

  assign out_valid  = ov_r && (st_r == ST_OUT);
  assign out_sample = res_r;
endmodule

[rtl/sepo_checker.sv]
// Checker: port-level properties of the oscillator, bound to the top level.
module sepo_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_sample
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready after accept");
  a_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample != 16'h8000)
    else $error("sample out of range");
endmodule

bind sine_edged_pulse_oscillator_core sepo_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_sample(out_sample)
);
